// ----- hw/rtl/ssi_pkg.sv -----
// Package for the sorted set insert block.
// Holds the value width, the entry-count output width, the token carried
// along the cell chain and the control state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssi_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned CountOutW = 7;
  localparam int unsigned DefCapacity = 64;

  // Token that walks the chain, one cell per cycle.
  typedef struct packed {
    logic                     valid;  // token present on this link
    logic                     ins;    // insert mode (store not full)
    logic                     hit;    // value found among the entries
    logic                     carry;  // data still has to be placed or searched
    logic signed [ValueW-1:0] data;   // value being placed or a displaced entry
  } tok_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/ssi_cell.sv -----
// One cell of the sorted set chain: holds a single entry and swaps it with
// a passing token when the token's value is smaller. Uses ssi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssi_cell #(
  parameter int unsigned CntW = 7
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ssi_pkg::tok_t      tok_i,
  input  wire logic [CntW-1:0]    rem_i,
  output ssi_pkg::tok_t           tok_o,
  output logic [CntW-1:0]         rem_o
);

  logic signed [ssi_pkg::ValueW-1:0] entry_q, entry_d;
  ssi_pkg::tok_t                     tok_q, tok_d;
  logic [CntW-1:0]                   rem_q, rem_d;

  always_comb begin
    tok_d   = tok_i;
    rem_d   = rem_i;
    entry_d = entry_q;
    if (tok_i.valid && tok_i.carry) begin
      if (rem_i == '0) begin
        // first free slot: place the carried value
        if (tok_i.ins) begin
          entry_d     = tok_i.data;
          tok_d.carry = 1'b0;
        end
      end else begin
        rem_d = rem_i - CntW'(1);
        if (entry_q == tok_i.data) begin
          tok_d.hit   = 1'b1;
          tok_d.carry = 1'b0;
        end else if (tok_i.ins && (entry_q > tok_i.data)) begin
          // take the smaller value, hand the old entry up the chain
          entry_d    = tok_i.data;
          tok_d.data = entry_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    entry_q <= entry_d;
  end

  assign tok_o = tok_q;
  assign rem_o = rem_q;

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_set_insert.sv -----
// Sorted set insert: ascending set of distinct signed 32-bit values.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / value_i) takes one value per
//   beat. Output channel (out_valid_o / out_stall_i) returns one result per
//   input beat: was_present_o, dropped_full_o and entry_count_o (count
//   after the step, low 7 bits).
//   An accepted value enters a chain of CAPACITY cells as a token and moves
//   one cell per cycle. Each cell compares its entry with the token, swaps
//   in the smaller value (insert), flags an equal entry (present), or just
//   searches when the store is full. The first free cell takes the value.
//   The token is registered in each cell in turn; the result is registered
//   when it leaves the last cell. Throughput is set by the walk of the
//   token through the cell chain; the block works on one item at a time.
//   The input stalls while a token is in the chain and while an earlier
//   result is still held on the output. A stalled result holds its value.
//   Reset clears the count and the control state; entries are undefined
//   until written and are never read beyond the count.
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_insert #(
  parameter int unsigned CAPACITY = ssi_pkg::DefCapacity
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [ssi_pkg::ValueW-1:0]  value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    was_present_o,
  output logic                                    dropped_full_o,
  output logic [ssi_pkg::CountOutW-1:0]           entry_count_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  ssi_pkg::tok_t   tok_w [CAPACITY+1];
  logic [CntW-1:0] rem_w [CAPACITY+1];

  ssi_pkg::state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            full;
  logic            in_acc;

  logic            out_valid_q, out_valid_d;
  logic            present_q, dropped_q;
  logic [CntW-1:0] out_count_q;
  logic [CntW+ssi_pkg::CountOutW-1:0] count_ext;

  assign full       = (count_q == CntW'(CAPACITY));
  assign in_stall_o = (state_q != ssi_pkg::ST_IDLE) | (out_valid_q & out_stall_i);
  assign in_acc     = in_valid_i & ~in_stall_o;

  // Inject the token at the head of the chain.
  always_comb begin
    tok_w[0]       = '0;
    tok_w[0].valid = in_acc;
    tok_w[0].ins   = ~full;
    tok_w[0].carry = 1'b1;
    tok_w[0].data  = value_i;
    rem_w[0]       = count_q;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ssi_cell #(
      .CntW (CntW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok_w[i]),
      .rem_i  (rem_w[i]),
      .tok_o  (tok_w[i+1]),
      .rem_o  (rem_w[i+1])
    );
  end

  // Run while the token walks; finish when it leaves the last cell.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q & out_stall_i;
    unique case (state_q)
      ssi_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = ssi_pkg::ST_RUN;
        end
      end
      ssi_pkg::ST_RUN: begin
        if (tok_w[CAPACITY].valid) begin
          state_d     = ssi_pkg::ST_IDLE;
          out_valid_d = 1'b1;
          if (tok_w[CAPACITY].ins && !tok_w[CAPACITY].hit) begin
            count_d = count_q + CntW'(1);
          end
        end
      end
      default: state_d = ssi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssi_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the result; hold it while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if ((state_q == ssi_pkg::ST_RUN) && tok_w[CAPACITY].valid) begin
      present_q   <= tok_w[CAPACITY].hit;
      dropped_q   <= ~tok_w[CAPACITY].hit & ~tok_w[CAPACITY].ins;
      out_count_q <= count_d;
    end
  end

  assign count_ext      = {{ssi_pkg::CountOutW{1'b0}}, out_count_q};
  assign out_valid_o    = out_valid_q;
  assign was_present_o  = present_q;
  assign dropped_full_o = dropped_q;
  assign entry_count_o  = count_ext[ssi_pkg::CountOutW-1:0];

endmodule

`default_nettype wire

// ----- verif/sorted_set_insert_test.sv -----
// Self-checking testbench for sorted_set_insert: drives signed values with random gaps
// and backpressure, predicts each result from a local ordered set and compares it.
// Depends on ssi_pkg and the sorted_set_insert RTL only.
`timescale 1ns / 1ps

module sorted_set_insert_test;

  localparam int unsigned Capacity  = ssi_pkg::DefCapacity;
  localparam int unsigned ValueW    = ssi_pkg::ValueW;
  localparam int unsigned CountOutW = ssi_pkg::CountOutW;
  // Longest quiet stretch of a correct run: the chain walk plus the longest
  // gap and the longest stall, taken many times over.
  localparam int unsigned IdleLimit = 20 * (Capacity + 1 + 2 * 15);

  typedef logic signed [ValueW-1:0] value_t;

  // One expected result, tagged with the value that caused it.
  typedef struct {
    value_t               value;
    logic                 was_present;
    logic                 dropped_full;
    logic [CountOutW-1:0] entry_count;
  } insert_outcome_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  value_t               value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 was_present_o;
  logic                 dropped_full_o;
  logic [CountOutW-1:0] entry_count_o;

  // Local copy of the ordered set; only slots below set_count are meaningful.
  value_t          set_entries [Capacity];
  int              set_count = 0;
  insert_outcome_t pending_outcomes [$];

  int          failures = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  sorted_set_insert #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .was_present_o (was_present_o),
    .dropped_full_o(dropped_full_o),
    .entry_count_o (entry_count_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Set predictor
  // ---------------------------------------------------------------------------

  // Look the value up, insert it at its sorted slot when absent and there is
  // room, and return the outcome of the step. The presence test comes first,
  // so a stored value reads as present even with the set full.
  function automatic insert_outcome_t insert_into_set(input value_t value);
    insert_outcome_t outcome;
    int              slot;
    outcome.value        = value;
    outcome.was_present  = 1'b0;
    outcome.dropped_full = 1'b0;
    slot = 0;
    while (slot < set_count && set_entries[slot] < value) slot++;
    if (slot < set_count && set_entries[slot] == value) begin
      outcome.was_present = 1'b1;
    end else if (set_count >= Capacity) begin
      outcome.dropped_full = 1'b1;
    end else begin
      // Shift every larger entry up by one slot, then drop the value in.
      for (int k = set_count; k > slot; k--) set_entries[k] = set_entries[k - 1];
      set_entries[slot] = value;
      set_count++;
    end
    outcome.entry_count = CountOutW'(set_count);
    return outcome;
  endfunction

  // Any value currently held in the set.
  function automatic value_t stored_value();
    return set_entries[$urandom_range(0, set_count - 1)];
  endfunction

  // Cycles one side waits before its next beat; zero throughout a calm stretch.
  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Send one value. Entered at a falling edge, either at the start or right
  // after the previous beat was taken; returns at the falling edge after the
  // beat is taken, with valid still high so that a back-to-back beat never
  // lowers and raises it within one step.
  task automatic send_value(input value_t value);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
    gap = draw_wait(in_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= value;
    // Hold the beat until the block stops stalling.
    do @(posedge clk_i); while (in_stall_o);
    pending_outcomes.push_back(insert_into_set(value));
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Hold each result for its drawn number of cycles; while nothing is offered,
  // toggle stall at random so that it also lands on the working phases.
  always @(negedge clk_i) begin
    if (out_valid_o) begin
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end else begin
      out_stall_i <= out_calm ? 1'b0 : 1'($urandom_range(0, 1));
    end
  end

  task automatic report_failure(input string what);
    failures++;
    if (failures <= 10) $display("mismatch: %s", what);
  endtask

  // Compare every taken result with the oldest expectation, field by field.
  always @(posedge clk_i) begin
    insert_outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outcomes.size() == 0) begin
        report_failure($sformatf("result with nothing expected: present=%0b dropped=%0b count=%0d",
                                 was_present_o, dropped_full_o, entry_count_o));
      end else begin
        want = pending_outcomes.pop_front();
        if (was_present_o !== want.was_present || dropped_full_o !== want.dropped_full ||
            entry_count_o !== want.entry_count) begin
          report_failure($sformatf(
            "value %0d: expected present=%0b dropped=%0b count=%0d, got %0b %0b %0d",
            want.value, want.was_present, want.dropped_full, want.entry_count,
            was_present_o, dropped_full_o, entry_count_o));
        end
      end
      if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
      hold_left = draw_wait(out_calm);
    end
  end

  // End the run when neither channel moves a beat for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("sorted_set_insert_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fill an empty set with the range extremes, landing at the end, the front
  // and the middle.
  task automatic test_extremes();
    send_value(value_t'(0));
    send_value(value_t'(32'h7FFF_FFFF));
    send_value(value_t'(32'h8000_0000));
    send_value(value_t'(-1));
    send_value(value_t'(1));
    send_value(value_t'(32'h7FFF_FFFE));
    send_value(value_t'(32'h8000_0001));
  endtask

  // Repeat stored values, including an insert followed at once by its twin.
  task automatic test_duplicates();
    value_t fresh;
    send_value(value_t'(32'h8000_0000));
    send_value(value_t'(32'h7FFF_FFFF));
    send_value(value_t'(0));
    send_value(value_t'(-1));
    fresh = $urandom();
    send_value(fresh);
    send_value(fresh);
    send_value(value_t'(32'h5555_5555));
    send_value(value_t'(32'hAAAA_AAAA));
    send_value(value_t'(32'h5555_5555));
    send_value(value_t'(32'hAAAA_AAAA));
  endtask

  // Grow the set to capacity. Lean on repeats and on neighbors of stored
  // values so that lookups keep hitting entry boundaries while it fills.
  task automatic test_growing_set();
    value_t value;
    while (set_count < Capacity) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: value = stored_value();
        5, 6:          value = stored_value() + value_t'($urandom_range(0, 1) ? 1 : -1);
        7:             value = value_t'($signed($urandom_range(0, 16)) - 8);
        default:       value = $urandom();
      endcase
      send_value(value);
    end
  endtask

  // With the set full, a stored value still reads as present and any other
  // value is dropped.
  task automatic test_full_store();
    value_t value;
    send_value(value_t'(32'h8000_0000));
    send_value(value_t'(32'h7FFF_FFFF));
    repeat (300) begin
      case ($urandom_range(0, 5))
        0, 1, 2: value = stored_value();
        3:       value = stored_value() + value_t'($urandom_range(0, 1) ? 1 : -1);
        default: value = $urandom();
      endcase
      send_value(value);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_extremes();
    test_duplicates();
    test_growing_set();
    test_full_store();

    // Drop valid, drain the results, then give the chain one more walk to
    // show anything unexpected.
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (Capacity + 4) @(posedge clk_i);

    if (failures == 0) begin
      $display("sorted_set_insert_test: PASS");
    end else begin
      $display("sorted_set_insert_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- sorted_set_insert.f -----
hw/rtl/ssi_pkg.sv
hw/rtl/ssi_cell.sv
hw/rtl/sorted_set_insert.sv
verif/sorted_set_insert_test.sv
